// File: rtl/core/dat_pkg.sv
// ----------------------------------------------------------------------------
// dat_pkg
// Shared constants, command/status codes and structs of the daily alarm table.
// ----------------------------------------------------------------------------
`default_nettype none

package dat_pkg;

  localparam int NUM_ALARMS  = 8;
  localparam int MAX_RESULTS = 8;

  localparam int IDX_W    = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int CMD_W    = 3;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int DATE_W   = 27;
  localparam int IDXIN_W  = 4;
  localparam int ID_W     = 3;
  localparam int STATUS_W = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  localparam logic [HOUR_W-1:0]  MAX_HOUR   = HOUR_W'(23);
  localparam logic [MIN_W-1:0]   MAX_MINUTE = MIN_W'(59);
  localparam logic [IDXIN_W:0]   NUM_ALARMS_L = (IDXIN_W + 1)'(NUM_ALARMS);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_ALARMS - 1);
  localparam logic [CNT_W-1:0]   MAX_RES_L  = CNT_W'(MAX_RESULTS);

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FORCE  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // one table entry as read out
  typedef struct packed {
    logic              enabled;
    logic              rpt;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              action;
    logic [DATE_W-1:0] fired_date;
  } dat_slot_t;

  // write controls for the entry at the current address
  typedef struct packed {
    logic              en_we;
    logic              en_val;
    logic              fld_we;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              action;
    logic              rep_we;
    logic              rep_val;
    logic              date_we;
    logic [DATE_W-1:0] date;
  } dat_wr_t;

  // latched request
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DATE_W-1:0] date;
    logic              action;
    logic              rpt;
    logic              en_val;
    logic [ID_W-1:0]   id;
    logic              in_range;
    logic              time_ok;
  } dat_req_t;

  function automatic logic [ID_W-1:0] to_id(input logic [IDX_W-1:0] i);
    logic [IDXIN_W-1:0] w;
    w = IDXIN_W'(i);
    return w[ID_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/daily_alarm_table.sv
// ----------------------------------------------------------------------------
// daily_alarm_table
// Tick and add (with a valid time) walk the table one entry per cycle
// through dat_match; a tick pauses while a new hit waits for the output
// register to take the held one.
// One request is in flight at a time; results wait in an output register.
// Synchronous active-low reset empties the table and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module daily_alarm_table (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // hour[4:0] minute[10:5] date_code[37:11] action_in[38] repeat_daily[39]
  // entry_index[43:40] enable_value[44], zero fill [47:45]
  input  wire logic [dat_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[2:0]
  input  wire logic [dat_pkg::CMD_W-1:0]         in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // status[1:0] entry_id[4:2] fired[5] action_out[6], zero fill [7]
  output logic [dat_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EXEC, ST_FIN} state_t;

  state_t                          state_r, state_nxt;
  dat_pkg::dat_req_t               req_r, req_nxt;
  logic [dat_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                            found_r, found_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [dat_pkg::ID_W-1:0]        pend_id_r, pend_id_nxt;
  logic                            pend_act_r, pend_act_nxt;
  logic [dat_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [dat_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [dat_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic                            out_fired_r, out_fired_nxt;
  logic                            out_act_r, out_act_nxt;
  logic                            out_last_r, out_last_nxt;

  dat_pkg::dat_wr_t                wr;
  dat_pkg::dat_slot_t              rd;
  logic                            hit;
  logic                            free;
  logic                            out_free;
  logic                            drop;
  logic                            stall;
  logic                            is_last;

  logic [dat_pkg::CMD_W-1:0]       i_cmd;
  logic [dat_pkg::HOUR_W-1:0]      i_hour;
  logic [dat_pkg::MIN_W-1:0]       i_minute;
  logic [dat_pkg::IDXIN_W-1:0]     i_index;
  logic                            i_in_range;
  logic                            i_time_ok;
  logic                            i_addr_cmd;

  dat_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .addr  (idx_r),
    .wr    (wr),
    .rd    (rd)
  );

  dat_match u_match (
    .slot   (rd),
    .hour   (req_r.hour),
    .minute (req_r.minute),
    .date   (req_r.date),
    .hit    (hit),
    .free   (free)
  );

  assign i_cmd      = in_tuser;
  assign i_hour     = in_tdata[4:0];
  assign i_minute   = in_tdata[10:5];
  assign i_index    = in_tdata[43:40];
  assign i_in_range = ({1'b0, i_index} < dat_pkg::NUM_ALARMS_L);
  assign i_time_ok  = (i_hour <= dat_pkg::MAX_HOUR) && (i_minute <= dat_pkg::MAX_MINUTE);
  assign i_addr_cmd = (i_cmd == dat_pkg::CMD_REMOVE) || (i_cmd == dat_pkg::CMD_ENABLE) ||
                      (i_cmd == dat_pkg::CMD_FORCE);

  assign out_free = !out_valid_r || out_tready;
  assign drop     = (cnt_r >= dat_pkg::MAX_RES_L);
  assign is_last  = (idx_r == dat_pkg::LAST_IDX);
  // a new hit must first push the held one out
  assign stall    = hit && !drop && pend_v_r && !out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_act_r, out_fired_r, out_id_r, out_status_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_act_nxt   = pend_act_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_fired_nxt  = out_fired_r;
    out_act_nxt    = out_act_r;
    out_last_nxt   = out_last_r;
    wr             = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt.cmd      = i_cmd;
          req_nxt.hour     = i_hour;
          req_nxt.minute   = i_minute;
          req_nxt.date     = in_tdata[37:11];
          req_nxt.action   = in_tdata[38];
          req_nxt.rpt      = in_tdata[39];
          req_nxt.en_val   = in_tdata[44];
          req_nxt.id       = i_index[dat_pkg::ID_W-1:0];
          req_nxt.in_range = i_in_range;
          req_nxt.time_ok  = i_time_ok;
          cnt_nxt          = '0;
          pend_v_nxt       = 1'b0;
          found_nxt        = 1'b0;
          idx_nxt          = (i_addr_cmd && i_in_range) ? i_index[dat_pkg::IDX_W-1:0] : '0;
          if ((i_cmd == dat_pkg::CMD_TICK) || ((i_cmd == dat_pkg::CMD_ADD) && i_time_ok)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_SCAN: begin
        if (req_r.cmd == dat_pkg::CMD_ADD) begin
          // first free entry wins
          if (free) begin
            found_nxt = 1'b1;
            state_nxt = ST_EXEC;
          end else if (is_last) begin
            state_nxt = ST_EXEC;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!stall) begin
          if (hit) begin
            wr.date_we = 1'b1;
            wr.date    = req_r.date;
            wr.en_we   = !rd.rpt;
            wr.en_val  = 1'b0;
            if (!drop) begin
              if (pend_v_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = dat_pkg::ST_OK;
                out_id_nxt     = pend_id_r;
                out_fired_nxt  = 1'b1;
                out_act_nxt    = pend_act_r;
                out_last_nxt   = 1'b0;
              end
              pend_v_nxt   = 1'b1;
              pend_id_nxt  = dat_pkg::to_id(idx_r);
              pend_act_nxt = rd.action;
              cnt_nxt      = cnt_r + 1'b1;
            end
          end
          if (is_last) begin
            state_nxt = ST_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = dat_pkg::ST_OK;
          out_id_nxt     = req_r.id;
          out_fired_nxt  = 1'b0;
          out_act_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
          case (req_r.cmd)
            dat_pkg::CMD_ADD: begin
              if (!req_r.time_ok) begin
                out_status_nxt = dat_pkg::ST_INVALID;
                out_id_nxt     = '0;
              end else if (!found_r) begin
                out_status_nxt = dat_pkg::ST_FULL;
                out_id_nxt     = '0;
              end else begin
                out_id_nxt  = dat_pkg::to_id(idx_r);
                wr.en_we    = 1'b1;
                wr.en_val   = 1'b1;
                wr.fld_we   = 1'b1;
                wr.hour     = req_r.hour;
                wr.minute   = req_r.minute;
                wr.action   = req_r.action;
                wr.rep_we   = 1'b1;
                wr.rep_val  = req_r.rpt;
                wr.date_we  = 1'b1;
                wr.date     = '0;
              end
            end
            dat_pkg::CMD_REMOVE: begin
              if (!req_r.in_range || !rd.enabled) begin
                out_status_nxt = dat_pkg::ST_INVALID;
              end else begin
                wr.en_we   = 1'b1;
                wr.en_val  = 1'b0;
                wr.rep_we  = 1'b1;
                wr.rep_val = 1'b0;
                wr.date_we = 1'b1;
                wr.date    = '0;
              end
            end
            dat_pkg::CMD_ENABLE: begin
              if (!req_r.in_range) begin
                out_status_nxt = dat_pkg::ST_INVALID;
              end else begin
                wr.en_we   = 1'b1;
                wr.en_val  = req_r.en_val;
                wr.date_we = !req_r.en_val;
                wr.date    = '0;
              end
            end
            dat_pkg::CMD_FORCE: begin
              if (!req_r.in_range || !rd.enabled) begin
                out_status_nxt = dat_pkg::ST_INVALID;
              end else begin
                out_fired_nxt = 1'b1;
                out_act_nxt   = rd.action;
              end
            end
            default: begin
              out_status_nxt = dat_pkg::ST_INVALID;
              out_id_nxt     = '0;
            end
          endcase
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_status_nxt = dat_pkg::ST_OK;
          out_id_nxt     = pend_v_r ? pend_id_r : '0;
          out_fired_nxt  = pend_v_r;
          out_act_nxt    = pend_v_r && pend_act_r;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_act_r   <= pend_act_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_fired_r  <= out_fired_nxt;
    out_act_r    <= out_act_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("held fire result left over in idle");

  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (cnt_r != '0))
    else $error("held fire result not counted");

  a_fin_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && out_free) |=> (out_valid_r && out_last_r && (state_r == ST_IDLE)))
    else $error("scan end did not deliver a last result");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= dat_pkg::LAST_IDX)
    else $error("entry address out of range");

endmodule

`default_nettype wire

// File: rtl/core/dat_slots.sv
// ----------------------------------------------------------------------------
// dat_slots
// Alarm entry storage: one write and one read port at a shared address.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_slots (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [dat_pkg::IDX_W-1:0]     addr,
  input  wire dat_pkg::dat_wr_t              wr,
  output dat_pkg::dat_slot_t                 rd
);

  logic                        en_r   [dat_pkg::NUM_ALARMS];
  logic                        rep_r  [dat_pkg::NUM_ALARMS];
  logic [dat_pkg::HOUR_W-1:0]  hour_r [dat_pkg::NUM_ALARMS];
  logic [dat_pkg::MIN_W-1:0]   min_r  [dat_pkg::NUM_ALARMS];
  logic                        act_r  [dat_pkg::NUM_ALARMS];
  logic [dat_pkg::DATE_W-1:0]  date_r [dat_pkg::NUM_ALARMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dat_pkg::NUM_ALARMS; i++) begin
        en_r[i]   <= 1'b0;
        rep_r[i]  <= 1'b0;
        hour_r[i] <= '0;
        min_r[i]  <= '0;
        act_r[i]  <= 1'b0;
        date_r[i] <= '0;
      end
    end else begin
      if (wr.en_we) en_r[addr] <= wr.en_val;
      if (wr.fld_we) begin
        hour_r[addr] <= wr.hour;
        min_r[addr]  <= wr.minute;
        act_r[addr]  <= wr.action;
      end
      if (wr.rep_we) rep_r[addr] <= wr.rep_val;
      if (wr.date_we) date_r[addr] <= wr.date;
    end
  end

  assign rd.enabled    = en_r[addr];
  assign rd.rpt        = rep_r[addr];
  assign rd.hour       = hour_r[addr];
  assign rd.minute     = min_r[addr];
  assign rd.action     = act_r[addr];
  assign rd.fired_date = date_r[addr];

endmodule

`default_nettype wire

// File: rtl/core/dat_match.sv
// ----------------------------------------------------------------------------
// dat_match
// Shared compare unit: tests one entry against the tick time and date.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_match (
  input  wire dat_pkg::dat_slot_t              slot,
  input  wire logic [dat_pkg::HOUR_W-1:0]      hour,
  input  wire logic [dat_pkg::MIN_W-1:0]       minute,
  input  wire logic [dat_pkg::DATE_W-1:0]      date,
  output logic                                 hit,
  output logic                                 free
);

  logic time_eq;
  logic done_today;

  assign time_eq    = (slot.hour == hour) && (slot.minute == minute);
  // one-shot entry already fired on this date stays quiet
  assign done_today = (slot.fired_date == date) && !slot.rpt;
  assign hit        = slot.enabled && time_eq && !done_today;
  assign free       = !slot.enabled;

endmodule

`default_nettype wire
